@@ rtl/owu_pkg.sv @@
// Shared types, constants and arithmetic helpers for the optimizer weight update engine.
// Used by optimizer_weight_update_top; depends on nothing else.

package owu_pkg;

   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 56;
   localparam int MOD_STEPS   = 16;

   localparam logic [2:0] CFG_ALGORITHM    = 3'd0;
   localparam logic [2:0] CFG_BASE_RATE    = 3'd1;
   localparam logic [2:0] CFG_MOMENTUM     = 3'd2;
   localparam logic [2:0] CFG_DECAY_FACTOR = 3'd3;
   localparam logic [2:0] CFG_DECAY_STEP   = 3'd4;

   localparam logic [1:0] OP_UPDATE    = 2'd0;
   localparam logic [1:0] OP_LOOKAHEAD = 2'd1;
   localparam logic [1:0] OP_TICK      = 2'd2;

   localparam logic [1:0] ALG_SGD      = 2'd0;
   localparam logic [1:0] ALG_NESTEROV = 2'd1;
   localparam logic [1:0] ALG_ADAGRAD  = 2'd2;

   localparam logic [24:0] BASE_RATE_RESET    = 25'd167772;
   localparam logic [24:0] MOMENTUM_RESET     = 25'd15099494;
   localparam logic [24:0] DECAY_FACTOR_RESET = 25'd16777216;
   localparam logic [15:0] DECAY_STEP_RESET   = 16'd65535;
   localparam logic [26:0] RATE_MAX           = 27'd33554431;

   localparam logic signed [57:0] VAL_MAX = 58'sd2147483647;
   localparam logic signed [57:0] VAL_MIN = -58'sd2147483648;

   typedef enum logic [1:0] {
      KIND_VEL,
      KIND_ADA,
      KIND_PASS,
      KIND_ZERO
   } kind_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              wr_vel;
      logic              wr_sum;
      logic              tick;
      logic              decay;
      logic [ADDR_W-1:0] addr;
      logic signed [31:0] w;
      logic signed [31:0] g;
   } front_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic              wr_vel;
      logic              wr_sum;
      logic              tick;
      logic              decay;
      logic [ADDR_W-1:0] addr;
      logic signed [31:0] w;
      logic              neg;
      logic signed [57:0] p_mv;
      logic signed [57:0] p_rg;
      logic [39:0]       sq;
      logic [47:0]       s_old;
      logic [49:0]       p_rate;
   } mid_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic signed [31:0] w;
      logic              neg;
      logic signed [35:0] opnd;
      logic [55:0]       num;
      logic [47:0]       s;
      logic              sat;
   } back_type;

   typedef struct packed {
      logic              valid;
      logic              ada_nz;
      logic              neg;
      logic signed [31:0] w;
      logic [55:0]       num;
      logic signed [31:0] res;
      logic              sat;
   } pay_type;

   typedef struct packed {
      pay_type     pay;
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rest;
   } sqrt_stage_type;

   typedef struct packed {
      pay_type     pay;
      logic [35:0] rem;
      logic [55:0] q;
      logic [55:0] rest;
      logic [35:0] den;
   } div_stage_type;

   typedef struct packed {
      logic signed [31:0] res;
      logic              sat;
   } result_type;

   // Round half up to Q.24: add one half, then an arithmetic shift floors.
   function automatic logic signed [35:0] round_q24(input logic signed [58:0] x);
      logic signed [58:0] t;
      t = x + 59'sd8388608;
      return 36'(t >>> 24);
   endfunction

   // Saturate to a signed 32-bit value; the top bit of the result is the clamp flag.
   function automatic logic [32:0] clamp_val(input logic signed [57:0] x);
      if (x > VAL_MAX) begin
         return {1'b1, 32'h7fffffff};
      end
      if (x < VAL_MIN) begin
         return {1'b1, 32'h80000000};
      end
      return {1'b0, x[31:0]};
   endfunction

   // One digit (two radicand bits) of the restoring square root.
   function automatic sqrt_stage_type sqrt_advance(input sqrt_stage_type s);
      logic [35:0] sh;
      logic [35:0] trial;
      sqrt_stage_type r;
      r = s;
      sh = {s.rem, s.rest[63:62]};
      trial = {2'b00, s.root, 2'b01};
      if (sh >= trial) begin
         r.rem = 34'(sh - trial);
         r.root = {s.root[30:0], 1'b1};
      end else begin
         r.rem = sh[33:0];
         r.root = {s.root[30:0], 1'b0};
      end
      r.rest = {s.rest[61:0], 2'b00};
      return r;
   endfunction

   // One quotient bit of the restoring divider.
   function automatic div_stage_type div_advance(input div_stage_type s);
      logic [36:0] sh;
      logic [36:0] den;
      div_stage_type r;
      r = s;
      sh = {s.rem, s.rest[55]};
      den = {1'b0, s.den};
      if (sh >= den) begin
         r.rem = 36'(sh - den);
         r.q = {s.q[54:0], 1'b1};
      end else begin
         r.rem = sh[35:0];
         r.q = {s.q[54:0], 1'b0};
      end
      r.rest = {s.rest[54:0], 1'b0};
      return r;
   endfunction

endpackage

@@ rtl/optimizer_weight_update_top.sv @@
// Top level of the optimizer weight update engine: decode, state stores, pipelines.
// Depends on owu_pkg for types, constants and the arithmetic step functions.
//
//  Channel  Direction  Handshake              Content
//  req_     in         req_valid/req_ready    opcode, element index, weight, gradient
//  rsp_     out        rsp_valid/rsp_ready    new or lookahead weight, saturation flag
//  csr_     in         csr_valid/csr_ready    register index, write data
//
// One request enters per cycle unless a hazard, the clearing pass, a phase rebuild or a full
// output buffer holds req_ready low. A request whose index matches one of the two updates just
// ahead of it waits, as does a request behind a tick, until the store write or decayed rate has landed.
// After reset a clearing pass zeroes both stores; a decay_step write starts a restoring modulo
// pass that rebuilds the tick phase. A two-entry output buffer absorbs rsp_ready stalls;
// the pipeline freezes only when it is full.

module optimizer_weight_update_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic [15:0]        req_element_index,
   input  logic signed [31:0] req_weight_in,
   input  logic signed [31:0] req_gradient,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_weight_out,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   // Configuration and scalar state.
   logic [1:0]  alg_ff;
   logic [24:0] mom_ff;
   logic [24:0] decay_ff;
   logic [15:0] step_ff;
   logic [24:0] rate_ff;
   logic [15:0] tick_cnt_ff;
   logic [15:0] tick_rem_ff;

   // Store clearing pass and tick phase rebuild.
   logic                            clr_busy_ff;
   logic [owu_pkg::ADDR_W-1:0]      clr_addr_ff;
   logic                            mod_busy_ff;
   logic [$clog2(owu_pkg::MOD_STEPS)-1:0] mod_cnt_ff;
   logic [15:0]                     mod_rem_ff;
   logic [15:0]                     mod_bits_ff;
   logic [15:0]                     mod_rem_in;

   // State stores.
   logic signed [31:0] vel_mem [owu_pkg::STORE_DEPTH];
   logic [47:0]        sum_mem [owu_pkg::STORE_DEPTH];
   logic signed [31:0] vel_rd_ff;
   logic [47:0]        sum_rd_ff;

   // Pipeline.
   owu_pkg::front_type      s1_ff, s1_in;
   owu_pkg::mid_type        s2_ff, s2_in;
   owu_pkg::back_type       s3_ff, s3_in;
   owu_pkg::sqrt_stage_type sq_ff [owu_pkg::SQRT_STEPS];
   owu_pkg::sqrt_stage_type sq_in [owu_pkg::SQRT_STEPS];
   owu_pkg::div_stage_type  dv_ff [owu_pkg::DIV_STEPS];
   owu_pkg::div_stage_type  dv_in [owu_pkg::DIV_STEPS];
   owu_pkg::pay_type        fin_ff, fin_in;

   // Output buffer.
   owu_pkg::result_type ob0_ff, ob1_ff;
   logic [1:0]          ob_cnt_ff;

   logic                        advance;
   logic                        accept;
   logic                        hazard;
   logic [owu_pkg::ADDR_W-1:0]  req_addr;
   logic [15:0]                 step_eff;
   logic [15:0]                 tick_cnt_in;
   logic [15:0]                 tick_rem_in;
   logic                        tick_decay;
   logic                        rate_sat;
   logic [24:0]                 rate_in;
   logic signed [31:0]          vel_wr;
   logic [47:0]                 sum_wr;
   logic                        vel_sat;
   logic                        sum_sat;
   logic                        push;
   logic                        pop;

   assign csr_ready = 1'b1;
   assign advance   = (ob_cnt_ff != 2'd2);
   assign req_addr  = req_element_index[owu_pkg::ADDR_W-1:0];
   assign step_eff  = (step_ff == 16'd0) ? 16'd1 : step_ff;

   // Requests that read a store entry still being rewritten ahead, or that follow a tick,
   // wait until that write has landed.
   assign hazard =
      (s1_ff.valid && (s1_ff.wr_vel || s1_ff.wr_sum) && (s1_ff.addr == req_addr)) ||
      (s2_ff.valid && (s2_ff.wr_vel || s2_ff.wr_sum) && (s2_ff.addr == req_addr)) ||
      (s1_ff.valid && s1_ff.tick) || (s2_ff.valid && s2_ff.tick);

   assign req_ready = advance && !clr_busy_ff && !mod_busy_ff && !hazard;
   assign accept    = req_valid && req_ready;

   // Tick phase: the remainder of the tick count by the decay step is kept incrementally.
   always_comb begin
      logic [16:0] rem_next;
      tick_cnt_in = tick_cnt_ff + 16'd1;
      rem_next = {1'b0, tick_rem_ff} + 17'd1;
      if (tick_cnt_in == 16'd0) begin
         tick_rem_in = 16'd0;
         tick_decay = 1'b1;
      end else if (rem_next == {1'b0, step_eff}) begin
         tick_rem_in = 16'd0;
         tick_decay = 1'b1;
      end else begin
         tick_rem_in = rem_next[15:0];
         tick_decay = 1'b0;
      end
   end

   // Restoring modulo step used to rebuild the phase after a decay_step write.
   always_comb begin
      logic [16:0] sh;
      sh = {mod_rem_ff, mod_bits_ff[15]};
      if (sh >= {1'b0, step_eff}) begin
         mod_rem_in = 16'(sh - {1'b0, step_eff});
      end else begin
         mod_rem_in = sh[15:0];
      end
   end

   // Request decode into the first stage.
   always_comb begin
      s1_in = '0;
      s1_in.valid = accept;
      s1_in.addr = req_addr;
      s1_in.w = req_weight_in;
      s1_in.g = req_gradient;
      s1_in.kind = owu_pkg::KIND_ZERO;
      unique case (req_opcode)
         owu_pkg::OP_UPDATE: begin
            if (alg_ff == owu_pkg::ALG_SGD || alg_ff == owu_pkg::ALG_NESTEROV) begin
               s1_in.kind = owu_pkg::KIND_VEL;
               s1_in.wr_vel = 1'b1;
            end else if (alg_ff == owu_pkg::ALG_ADAGRAD) begin
               s1_in.kind = owu_pkg::KIND_ADA;
               s1_in.wr_sum = 1'b1;
            end else begin
               s1_in.kind = owu_pkg::KIND_PASS;
            end
         end
         owu_pkg::OP_LOOKAHEAD: begin
            if (alg_ff == owu_pkg::ALG_NESTEROV) begin
               // The rate term drops out when the gradient is zero.
               s1_in.kind = owu_pkg::KIND_VEL;
               s1_in.g = '0;
            end else begin
               s1_in.kind = owu_pkg::KIND_PASS;
            end
         end
         owu_pkg::OP_TICK: begin
            s1_in.tick = 1'b1;
            s1_in.decay = tick_decay;
         end
         default: begin
            s1_in.kind = owu_pkg::KIND_ZERO;
         end
      endcase
   end

   // Stage two: all products.
   always_comb begin
      logic [31:0] mag;
      logic [63:0] sq_full;
      mag = s1_ff.g[31] ? 32'(-s1_ff.g) : 32'(s1_ff.g);
      sq_full = 64'(mag) * 64'(mag);
      s2_in.valid = s1_ff.valid;
      s2_in.kind = s1_ff.kind;
      s2_in.wr_vel = s1_ff.wr_vel;
      s2_in.wr_sum = s1_ff.wr_sum;
      s2_in.tick = s1_ff.tick;
      s2_in.decay = s1_ff.decay;
      s2_in.addr = s1_ff.addr;
      s2_in.w = s1_ff.w;
      s2_in.neg = s1_ff.g[31];
      s2_in.p_mv = 58'($signed({1'b0, mom_ff})) * 58'(vel_rd_ff);
      s2_in.p_rg = 58'($signed({1'b0, rate_ff})) * 58'(s1_ff.g);
      s2_in.sq = sq_full[63:24];
      s2_in.s_old = sum_rd_ff;
      s2_in.p_rate = 50'(rate_ff) * 50'(decay_ff);
   end

   // Stage three: new velocity, new square sum, decayed rate; stores are written here.
   always_comb begin
      logic signed [58:0] acc;
      logic signed [35:0] rnd;
      logic [32:0]        vcl;
      logic [48:0]        ssum;
      logic [50:0]        rt;
      acc = 59'(s2_ff.p_mv) - 59'(s2_ff.p_rg);
      rnd = owu_pkg::round_q24(acc);
      vcl = owu_pkg::clamp_val(58'(rnd));
      vel_wr = vcl[31:0];
      vel_sat = vcl[32];
      ssum = 49'(s2_ff.s_old) + 49'(s2_ff.sq);
      sum_sat = ssum[48];
      sum_wr = ssum[48] ? '1 : ssum[47:0];
      rt = {1'b0, s2_ff.p_rate} + 51'd8388608;
      rate_sat = (rt[50:24] > owu_pkg::RATE_MAX);
      rate_in = rate_sat ? owu_pkg::RATE_MAX[24:0] : rt[48:24];

      s3_in.valid = s2_ff.valid;
      s3_in.kind = s2_ff.kind;
      s3_in.w = s2_ff.w;
      s3_in.neg = s2_ff.neg;
      s3_in.opnd = s2_ff.wr_vel ? 36'(vel_wr) : rnd;
      s3_in.num = s2_ff.p_rg[57] ? 56'(-s2_ff.p_rg) : 56'(s2_ff.p_rg);
      s3_in.s = sum_wr;
      s3_in.sat = (s2_ff.wr_vel && vel_sat) || (s2_ff.wr_sum && sum_sat) ||
                  (s2_ff.decay && rate_sat);
   end

   // Stage four: momentum result, then the square root begins on the AdaGrad sum.
   always_comb begin
      owu_pkg::sqrt_stage_type init;
      logic [32:0] wcl;
      wcl = owu_pkg::clamp_val(58'(s3_ff.w) + 58'(s3_ff.opnd));
      init = '0;
      init.pay.valid = s3_ff.valid;
      init.pay.ada_nz = (s3_ff.kind == owu_pkg::KIND_ADA) && (s3_ff.s != 48'd0);
      init.pay.neg = s3_ff.neg;
      init.pay.w = s3_ff.w;
      init.pay.num = s3_ff.num;
      init.pay.sat = s3_ff.sat;
      case (s3_ff.kind)
         owu_pkg::KIND_VEL: begin
            init.pay.res = wcl[31:0];
            init.pay.sat = s3_ff.sat || wcl[32];
         end
         owu_pkg::KIND_ZERO: begin
            init.pay.res = '0;
         end
         default: begin
            init.pay.res = s3_ff.w;
         end
      endcase
      init.rest = {s3_ff.s, 16'd0};
      sq_in[0] = owu_pkg::sqrt_advance(init);
      for (int k = 1; k < owu_pkg::SQRT_STEPS; k++) begin
         sq_in[k] = owu_pkg::sqrt_advance(sq_ff[k-1]);
      end
   end

   // Divider: rate times gradient magnitude over sixteen times the root.
   always_comb begin
      owu_pkg::div_stage_type init;
      init = '0;
      init.pay = sq_ff[owu_pkg::SQRT_STEPS-1].pay;
      init.rest = sq_ff[owu_pkg::SQRT_STEPS-1].pay.num;
      init.den = {sq_ff[owu_pkg::SQRT_STEPS-1].root, 4'd0};
      dv_in[0] = owu_pkg::div_advance(init);
      for (int k = 1; k < owu_pkg::DIV_STEPS; k++) begin
         dv_in[k] = owu_pkg::div_advance(dv_ff[k-1]);
      end
   end

   // Final AdaGrad weight step.
   always_comb begin
      logic signed [57:0] diff;
      logic [32:0]        wcl;
      owu_pkg::div_stage_type last;
      last = dv_ff[owu_pkg::DIV_STEPS-1];
      if (last.pay.neg) begin
         diff = 58'(last.pay.w) + $signed({2'b00, last.q});
      end else begin
         diff = 58'(last.pay.w) - $signed({2'b00, last.q});
      end
      wcl = owu_pkg::clamp_val(diff);
      fin_in = last.pay;
      if (last.pay.ada_nz) begin
         fin_in.res = wcl[31:0];
         fin_in.sat = last.pay.sat || wcl[32];
      end
   end

   // Pipeline registers; only the valid bits are reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         fin_ff.valid <= 1'b0;
         for (int k = 0; k < owu_pkg::SQRT_STEPS; k++) begin
            sq_ff[k].pay.valid <= 1'b0;
         end
         for (int k = 0; k < owu_pkg::DIV_STEPS; k++) begin
            dv_ff[k].pay.valid <= 1'b0;
         end
      end else if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         fin_ff <= fin_in;
         for (int k = 0; k < owu_pkg::SQRT_STEPS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         for (int k = 0; k < owu_pkg::DIV_STEPS; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   // State stores: the clearing pass and stage three share the single write port.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         vel_mem[clr_addr_ff] <= '0;
         sum_mem[clr_addr_ff] <= '0;
      end else if (advance && s2_ff.valid) begin
         if (s2_ff.wr_vel) begin
            vel_mem[s2_ff.addr] <= vel_wr;
         end
         if (s2_ff.wr_sum) begin
            sum_mem[s2_ff.addr] <= sum_wr;
         end
      end
      if (advance) begin
         vel_rd_ff <= vel_mem[req_addr];
         sum_rd_ff <= sum_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + owu_pkg::ADDR_W'(1);
         if (clr_addr_ff == owu_pkg::ADDR_W'(owu_pkg::STORE_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Configuration, learning rate and tick phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff <= owu_pkg::ALG_SGD;
         mom_ff <= owu_pkg::MOMENTUM_RESET;
         decay_ff <= owu_pkg::DECAY_FACTOR_RESET;
         step_ff <= owu_pkg::DECAY_STEP_RESET;
         rate_ff <= owu_pkg::BASE_RATE_RESET;
         tick_cnt_ff <= '0;
         tick_rem_ff <= '0;
         mod_busy_ff <= 1'b0;
         mod_cnt_ff <= '0;
         mod_rem_ff <= '0;
         mod_bits_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               owu_pkg::CFG_ALGORITHM: begin
                  alg_ff <= csr_data[1:0];
               end
               owu_pkg::CFG_BASE_RATE: begin
                  rate_ff <= csr_data[24:0];
                  tick_cnt_ff <= '0;
                  tick_rem_ff <= '0;
                  mod_busy_ff <= 1'b0;
               end
               owu_pkg::CFG_MOMENTUM: begin
                  mom_ff <= csr_data[24:0];
               end
               owu_pkg::CFG_DECAY_FACTOR: begin
                  decay_ff <= csr_data[24:0];
               end
               owu_pkg::CFG_DECAY_STEP: begin
                  step_ff <= csr_data[15:0];
                  mod_busy_ff <= 1'b1;
                  mod_cnt_ff <= '0;
                  mod_rem_ff <= '0;
                  mod_bits_ff <= tick_cnt_ff;
               end
               default: begin
               end
            endcase
         end else if (mod_busy_ff) begin
            mod_rem_ff <= mod_rem_in;
            mod_bits_ff <= {mod_bits_ff[14:0], 1'b0};
            mod_cnt_ff <= mod_cnt_ff + ($clog2(owu_pkg::MOD_STEPS))'(1);
            if (mod_cnt_ff == ($clog2(owu_pkg::MOD_STEPS))'(owu_pkg::MOD_STEPS - 1)) begin
               mod_busy_ff <= 1'b0;
               tick_rem_ff <= mod_rem_in;
            end
         end else begin
            if (accept && req_opcode == owu_pkg::OP_TICK) begin
               tick_cnt_ff <= tick_cnt_in;
               tick_rem_ff <= tick_rem_in;
            end
            if (advance && s2_ff.valid && s2_ff.decay) begin
               rate_ff <= rate_in;
            end
         end
      end
   end

   // Two-entry output buffer; the head entry drives the response ports.
   assign push = advance && fin_ff.valid;
   assign pop  = (ob_cnt_ff != 2'd0) && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_cnt_ff <= 2'd0;
      end else begin
         case (ob_cnt_ff)
            2'd0: begin
               if (push) begin
                  ob0_ff <= '{res: fin_ff.res, sat: fin_ff.sat};
                  ob_cnt_ff <= 2'd1;
               end
            end
            2'd1: begin
               if (push && pop) begin
                  ob0_ff <= '{res: fin_ff.res, sat: fin_ff.sat};
               end else if (push) begin
                  ob1_ff <= '{res: fin_ff.res, sat: fin_ff.sat};
                  ob_cnt_ff <= 2'd2;
               end else if (pop) begin
                  ob_cnt_ff <= 2'd0;
               end
            end
            default: begin
               if (pop) begin
                  ob0_ff <= ob1_ff;
                  ob_cnt_ff <= 2'd1;
               end
            end
         endcase
      end
   end

   assign rsp_valid      = (ob_cnt_ff != 2'd0);
   assign rsp_weight_out = ob0_ff.res;
   assign rsp_saturated  = ob0_ff.sat;

endmodule
